// ----- hdl/mlpg_pkg.sv -----
// types and constants shared by the midpoint line pixel generator and its checker
// no dependencies
`default_nettype none

package mlpg_pkg;

    // command codes on the input channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // octant case of the active line
    typedef struct packed {
        logic cmp_neg;    // take the diagonal step on a positive decision
        logic minor_neg;  // minor axis steps down
        logic major_neg;  // major axis steps down
        logic swap;       // major axis is y
    } octant_t;

endpackage

`default_nettype wire

// ----- hdl/midpoint_line_pixel_generator.sv -----
// midpoint line pixel generator: line setup and per-step pixel emission
// depends on mlpg_pkg
`default_nettype none
//
// Input channel (in_valid / in_stall): a start word (cmd = CMD_START) loads two
// endpoints and a colour and emits nothing; any line still being drawn is
// dropped. Each step word (cmd = CMD_STEP) emits one pixel of the active line,
// running from the endpoint with the smaller x toward the other one. The far
// endpoint comes last with last_pixel set, and that ends the line. A step word
// with no active line emits nothing.
// Output channel (out_valid / out_stall): one word per pixel.
// A step word is taken into the input register, and its pixel is then written
// to the result register. Throughput: one word per cycle while out_stall is low,
// set by the combinational setup and decision update between the two registers.
// Reset clears both registers' valid flags and the active-line flag.
// While the receiver stalls with a pixel waiting, one more word is taken into
// the input register; after that in_stall is raised until the pixel is taken.
//
module midpoint_line_pixel_generator
    import mlpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    input  wire logic [31:0]           line_colour,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic [31:0]                pixel_colour,
    output logic                       last_pixel
);

    localparam int UPD_BITS = COORD_BITS + 4;
    localparam int DEC_BITS = COORD_BITS + 6;

    // input register
    logic                  in_valid_reg;
    logic                  in_cmd_reg;
    logic [COORD_BITS-1:0] in_sx_reg;
    logic [COORD_BITS-1:0] in_sy_reg;
    logic [COORD_BITS-1:0] in_ex_reg;
    logic [COORD_BITS-1:0] in_ey_reg;
    logic [31:0]           in_colour_reg;

    // line state
    logic                       line_active_reg, line_active_next;
    logic [COORD_BITS-1:0]      major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]      minor_pos_reg, minor_pos_next;
    logic [COORD_BITS-1:0]      major_end_reg, major_end_next;
    logic [COORD_BITS-1:0]      final_x_reg, final_x_next;
    logic [COORD_BITS-1:0]      final_y_reg, final_y_next;
    logic signed [DEC_BITS-1:0] decision_reg, decision_next;
    logic signed [UPD_BITS-1:0] straight_reg, straight_next;
    logic signed [UPD_BITS-1:0] diagonal_reg, diagonal_next;
    octant_t                    octant_reg, octant_next;
    logic [31:0]                colour_reg, colour_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic [31:0]           pixel_colour_reg, pixel_colour_next;
    logic                  last_pixel_reg, last_pixel_next;

    logic advance;
    logic process;

    // setup terms
    logic [COORD_BITS-1:0]      x0, y0, x1, y1;
    logic [COORD_BITS-1:0]      a0, b0, a1, b1;
    logic [COORD_BITS-1:0]      dx, dy_abs;
    logic                       y_up;
    octant_t                    oct_setup;
    logic signed [UPD_BITS-1:0] diff_a, diff_b, straight_setup, diagonal_setup;
    logic signed [DEC_BITS-1:0] decision_setup;

    // step terms
    logic at_end;
    logic take_diag;

    assign advance  = !out_valid_reg || !out_stall;
    assign process  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        // order the endpoints so that x does not fall
        if (in_sx_reg > in_ex_reg)
        begin
            x0 = in_ex_reg;
            y0 = in_ey_reg;
            x1 = in_sx_reg;
            y1 = in_sy_reg;
        end
        else
        begin
            x0 = in_sx_reg;
            y0 = in_sy_reg;
            x1 = in_ex_reg;
            y1 = in_ey_reg;
        end
        dx     = x1 - x0;
        y_up   = (y1 >= y0);
        dy_abs = y_up ? (y1 - y0) : (y0 - y1);

        oct_setup = '0;
        if (y_up && (dx > dy_abs))
        begin
            oct_setup = '0;
        end
        else if (!y_up && (dx >= dy_abs))
        begin
            oct_setup.minor_neg = 1'b1;
            oct_setup.cmp_neg   = 1'b1;
        end
        else if (y_up)
        begin
            oct_setup.swap = 1'b1;
        end
        else
        begin
            oct_setup.swap      = 1'b1;
            oct_setup.major_neg = 1'b1;
            oct_setup.cmp_neg   = 1'b1;
        end

        if (oct_setup.swap)
        begin
            a0 = y0;
            b0 = x0;
            a1 = y1;
            b1 = x1;
        end
        else
        begin
            a0 = x0;
            b0 = y0;
            a1 = x1;
            b1 = y1;
        end

        diff_a = UPD_BITS'($signed({1'b0, a1})) - UPD_BITS'($signed({1'b0, a0}));
        diff_b = UPD_BITS'($signed({1'b0, b0})) - UPD_BITS'($signed({1'b0, b1}));

        straight_setup = oct_setup.major_neg ? -(diff_b <<< 1) : (diff_b <<< 1);
        diagonal_setup = (oct_setup.minor_neg ? -(diff_a <<< 1) : (diff_a <<< 1))
                         + straight_setup;
        decision_setup = DEC_BITS'(straight_setup)
                         + (oct_setup.minor_neg ? -DEC_BITS'(diff_a) : DEC_BITS'(diff_a));
    end

    always_comb
    begin
        at_end = (major_pos_reg == major_end_reg);
        // compare on the negated decision where the octant asks for it
        if (octant_reg.cmp_neg)
        begin
            take_diag = !decision_reg[DEC_BITS-1] && (decision_reg != '0);
        end
        else
        begin
            take_diag = decision_reg[DEC_BITS-1];
        end
    end

    always_comb
    begin
        line_active_next  = line_active_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        final_x_next      = final_x_reg;
        final_y_next      = final_y_reg;
        decision_next     = decision_reg;
        straight_next     = straight_reg;
        diagonal_next     = diagonal_reg;
        octant_next       = octant_reg;
        colour_next       = colour_reg;
        out_valid_next    = out_valid_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pixel_colour_next = pixel_colour_reg;
        last_pixel_next   = last_pixel_reg;

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (process)
        begin
            out_valid_next = 1'b0;
            if (in_cmd_reg == CMD_START)
            begin
                line_active_next = 1'b1;
                major_pos_next   = a0;
                minor_pos_next   = b0;
                major_end_next   = a1;
                final_x_next     = x1;
                final_y_next     = y1;
                decision_next    = decision_setup;
                straight_next    = straight_setup;
                diagonal_next    = diagonal_setup;
                octant_next      = oct_setup;
                colour_next      = in_colour_reg;
            end
            else if (line_active_reg)
            begin
                out_valid_next    = 1'b1;
                pixel_colour_next = colour_reg;
                if (at_end)
                begin
                    pixel_x_next     = final_x_reg;
                    pixel_y_next     = final_y_reg;
                    last_pixel_next  = 1'b1;
                    line_active_next = 1'b0;
                end
                else
                begin
                    pixel_x_next    = octant_reg.swap ? minor_pos_reg : major_pos_reg;
                    pixel_y_next    = octant_reg.swap ? major_pos_reg : minor_pos_reg;
                    last_pixel_next = 1'b0;
                    if (take_diag)
                    begin
                        minor_pos_next = octant_reg.minor_neg ? (minor_pos_reg - 1'b1)
                                                              : (minor_pos_reg + 1'b1);
                        decision_next  = decision_reg + DEC_BITS'(diagonal_reg);
                    end
                    else
                    begin
                        decision_next  = decision_reg + DEC_BITS'(straight_reg);
                    end
                    major_pos_next = octant_reg.major_neg ? (major_pos_reg - 1'b1)
                                                          : (major_pos_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_cmd_reg    <= cmd;
            in_sx_reg     <= start_x;
            in_sy_reg     <= start_y;
            in_ex_reg     <= end_x;
            in_ey_reg     <= end_y;
            in_colour_reg <= line_colour;
        end
        major_pos_reg    <= major_pos_next;
        minor_pos_reg    <= minor_pos_next;
        major_end_reg    <= major_end_next;
        final_x_reg      <= final_x_next;
        final_y_reg      <= final_y_next;
        decision_reg     <= decision_next;
        straight_reg     <= straight_next;
        diagonal_reg     <= diagonal_next;
        octant_reg       <= octant_next;
        colour_reg       <= colour_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        pixel_colour_reg <= pixel_colour_next;
        last_pixel_reg   <= last_pixel_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_colour = pixel_colour_reg;
    assign last_pixel   = last_pixel_reg;

endmodule

`default_nettype wire

// ----- hdl/mlpg_checker.sv -----
// port-level assertions for the midpoint line pixel generator, bound to the top level
// depends on mlpg_pkg and midpoint_line_pixel_generator
`default_nettype none

module mlpg_checker
    import mlpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  cmd,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COORD_BITS-1:0] pixel_x,
    input wire logic [COORD_BITS-1:0] pixel_y,
    input wire logic [31:0]           pixel_colour,
    input wire logic                  last_pixel
);

    // a stalled pixel word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_colour) && $stable(last_pixel))
        else $error("stalled output word changed");

    // input backs up only behind a waiting, stalled pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    // a start word that moves on produces no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_START) ##1 !out_stall |=> !out_valid)
        else $error("start word produced a pixel");

endmodule

bind midpoint_line_pixel_generator mlpg_checker #(.COORD_BITS(COORD_BITS)) u_mlpg_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for midpoint_line_pixel_generator: directed and random line words,
// pixels predicted in the bench and checked in order; depends on mlpg_pkg and the block rtl

module tb;
    import mlpg_pkg::*;

    localparam int CW          = 12;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic          cmd;
        logic [CW-1:0] sx, sy, ex, ey;
        logic [31:0]   colour;
        int            gap;
        bit            drain;
    } line_word_t;

    typedef struct {
        logic [CW-1:0] x, y;
        logic [31:0]   colour;
        logic          last;
    } pixel_t;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          cmd         = CMD_START;
    logic [CW-1:0] start_x     = '0;
    logic [CW-1:0] start_y     = '0;
    logic [CW-1:0] end_x       = '0;
    logic [CW-1:0] end_y       = '0;
    logic [31:0]   line_colour = '0;
    logic          out_stall   = 1'b0;
    logic          in_stall;
    logic          out_valid;
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic [31:0]   pixel_colour;
    logic          last_pixel;

    // line state of the predictor, cleared as the block is after reset
    logic                 line_on       = 1'b0;
    logic [CW-1:0]        major_at      = '0;
    logic [CW-1:0]        minor_at      = '0;
    logic [CW-1:0]        major_stop    = '0;
    logic [CW-1:0]        stop_x        = '0;
    logic [CW-1:0]        stop_y        = '0;
    logic signed [17:0]   err_term      = '0;
    logic signed [15:0]   straight_step = '0;
    logic signed [15:0]   diag_step     = '0;
    octant_t              oct           = '0;
    logic [31:0]          held_colour   = '0;

    line_word_t word_queue[$];
    pixel_t     pixel_queue[$];
    line_word_t cur_word;

    int idle_count    = 0;
    int hold_left     = 0;
    int words_taken   = 0;
    int total_words   = 0;
    int lines_started = 0;
    int pixels_seen   = 0;
    int ends_seen     = 0;
    int mismatches    = 0;
    int cycles        = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;

    midpoint_line_pixel_generator #(
        .COORD_BITS(CW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .line_colour  (line_colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic void push_word(logic c, int sx, int sy, int ex, int ey,
                                      logic [31:0] col, bit drain);
        line_word_t w;
        w.cmd    = c;
        w.sx     = sx[CW-1:0];
        w.sy     = sy[CW-1:0];
        w.ex     = ex[CW-1:0];
        w.ey     = ey[CW-1:0];
        w.colour = col;
        w.gap    = draw_wait(tx_calm);
        w.drain  = drain;
        word_queue.push_back(w);
    endfunction

    // step words carry junk in the unused fields
    function automatic void push_steps(int n);
        repeat (n)
        begin
            push_word(CMD_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom, 1'b0);
        end
    endfunction

    function automatic int near(int base, int span);
        int off;
        int v;
        off = int'($urandom_range(0, 2 * span)) - span;
        v = base + off;
        if (v < 0 || v > COORD_MAX)
            v = base - off;
        if (v < 0 || v > COORD_MAX)
            v = base;
        return v;
    endfunction

    // midpoint line walk: start words set up the octant, step words emit one pixel each
    task automatic advance_line(input line_word_t w);
        pixel_t             px;
        logic signed [17:0] cmp;
        logic [CW-1:0]      lo_x, lo_y, hi_x, hi_y, tmp;
        int                 run, rise, a0, b0, a1, b1, sx, sy;
        if (w.cmd == CMD_START)
        begin
            lo_x = w.sx;
            lo_y = w.sy;
            hi_x = w.ex;
            hi_y = w.ey;
            if (lo_x > hi_x)
            begin
                tmp = lo_x; lo_x = hi_x; hi_x = tmp;
                tmp = lo_y; lo_y = hi_y; hi_y = tmp;
            end
            run  = int'(hi_x) - int'(lo_x);
            rise = int'(hi_y) - int'(lo_y);
            oct  = '0;
            // exact diagonals go steep when rising, shallow when falling
            if (rise >= 0 && run > rise)
                oct = '0;
            else if (rise < 0 && run >= -rise)
            begin
                oct.minor_neg = 1'b1;
                oct.cmp_neg   = 1'b1;
            end
            else if (rise >= 0)
                oct.swap = 1'b1;
            else
            begin
                oct.swap      = 1'b1;
                oct.major_neg = 1'b1;
                oct.cmp_neg   = 1'b1;
            end
            if (oct.swap)
            begin
                a0 = lo_y; b0 = lo_x; a1 = hi_y; b1 = hi_x;
            end
            else
            begin
                a0 = lo_x; b0 = lo_y; a1 = hi_x; b1 = hi_y;
            end
            sx = oct.major_neg ? -1 : 1;
            sy = oct.minor_neg ? -1 : 1;
            straight_step = 16'(2 * sx * (b0 - b1));
            diag_step     = 16'(2 * sy * (a1 - a0) + 2 * sx * (b0 - b1));
            err_term      = 18'(2 * sx * (b0 - b1) + sy * (a1 - a0));
            major_at      = a0[CW-1:0];
            minor_at      = b0[CW-1:0];
            major_stop    = a1[CW-1:0];
            stop_x        = hi_x;
            stop_y        = hi_y;
            held_colour   = w.colour;
            line_on       = 1'b1;
            lines_started++;
        end
        else if (line_on)
        begin
            px.colour = held_colour;
            if (major_at == major_stop)
            begin
                px.x    = stop_x;
                px.y    = stop_y;
                px.last = 1'b1;
                line_on = 1'b0;
            end
            else
            begin
                px.x    = oct.swap ? minor_at : major_at;
                px.y    = oct.swap ? major_at : minor_at;
                px.last = 1'b0;
                cmp = oct.cmp_neg ? -err_term : err_term;
                if (cmp < 0)
                begin
                    minor_at = oct.minor_neg ? minor_at - 1'b1 : minor_at + 1'b1;
                    err_term = err_term + diag_step;
                end
                else
                    err_term = err_term + straight_step;
                major_at = oct.major_neg ? major_at - 1'b1 : major_at + 1'b1;
            end
            pixel_queue.push_back(px);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_line(cur_word);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (word_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_count < word_queue[0].gap ||
                         (word_queue[0].drain && pixel_queue.size() != 0))
                begin
                    in_valid <= 1'b0;
                    idle_count++;
                end
                else
                begin
                    cur_word    = word_queue.pop_front();
                    idle_count  = 0;
                    in_valid    <= 1'b1;
                    cmd         <= cur_word.cmd;
                    start_x     <= cur_word.sx;
                    start_y     <= cur_word.sy;
                    end_x       <= cur_word.ex;
                    end_y       <= cur_word.ey;
                    line_colour <= cur_word.colour;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : rx_side
        pixel_t want;
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            if (out_valid && !out_stall)
            begin
                pixels_seen++;
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: pixel (%0d,%0d) with none expected, expected none got word",
                             $time, pixel_x, pixel_y);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    check_field("pixel_x", 32'(want.x), 32'(pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pixel_y));
                    check_field("pixel_colour", want.colour, pixel_colour);
                    check_field("last_pixel", 32'(want.last), 32'(last_pixel));
                    if (want.last)
                        ends_seen++;
                end
                hold_left = draw_wait(rx_calm);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int x0, y0, x1, y1, dxa, dya, len, span, steps, pick, n_rand;
        bit drain_next;
        n_rand     = 0;
        drain_next = 1'b1;

        // directed: idle step, single point, extremes with early abandon, ties, steep down
        push_steps(1);
        push_word(CMD_START, 5, 7, 5, 7, 32'h0000_0000, 1'b0);
        push_steps(2);
        push_word(CMD_START, COORD_MAX, 0, 0, COORD_MAX, 32'hffff_ffff, 1'b0);
        push_steps(1);
        push_word(CMD_START, 0, 0, COORD_MAX, COORD_MAX, 32'h5a5a_a5a5, 1'b0);
        push_steps(1);
        push_word(CMD_START, 10, 20, 13, 23, 32'h1234_5678, 1'b0);
        push_steps(4);
        push_word(CMD_START, 13, 20, 10, 23, 32'h8765_4321, 1'b0);
        push_steps(4);
        push_word(CMD_START, 2, 1, 1, 6, 32'hc0ff_ee00, 1'b0);
        push_steps(6);

        // random: mostly complete lines, some cut short or overrun, a little noise
        while (n_rand < 1900)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_calm = !tx_calm;
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                if (pick < 3)
                    push_steps(1);
                else
                    push_word(CMD_START, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom, 1'b0);
                n_rand++;
            end
            else
            begin
                x0   = $urandom_range(0, COORD_MAX);
                y0   = $urandom_range(0, COORD_MAX);
                span = (pick < 80) ? 12 : (pick < 95) ? 200 : COORD_MAX;
                x1   = near(x0, span);
                y1   = near(y0, span);
                case ($urandom_range(0, 9))
                    0: y1 = y0;
                    1: x1 = x0;
                    2:
                    begin
                        y1 = y0 + (x1 - x0);
                        if (y1 < 0 || y1 > COORD_MAX)
                            y1 = y0 - (x1 - x0);
                        if (y1 < 0 || y1 > COORD_MAX)
                            y1 = y0;
                    end
                    default: ;
                endcase
                dxa = (x1 > x0) ? x1 - x0 : x0 - x1;
                dya = (y1 > y0) ? y1 - y0 : y0 - y1;
                len = ((dxa > dya) ? dxa : dya) + 1;
                case ($urandom_range(0, 9))
                    0:       steps = $urandom_range(0, len - 1);
                    1:       steps = len + $urandom_range(1, 3);
                    default: steps = len;
                endcase
                if (span == COORD_MAX && steps > 60)
                    steps = $urandom_range(1, 60);
                push_word(CMD_START, x0, y0, x1, y1, $urandom, drain_next);
                push_steps(steps);
                drain_next = ($urandom_range(0, 49) == 0);
                n_rand += steps + 1;
            end
        end
        total_words = word_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken != total_words)
            @(posedge clk);
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("tb: %0d words taken, %0d lines started, %0d pixels checked, %0d line ends",
                 words_taken, lines_started, pixels_seen, ends_seen);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mlpg_pkg.sv
hdl/midpoint_line_pixel_generator.sv
hdl/mlpg_checker.sv
tb/tb.sv
